// File: hw/rtl/ari_pkg.sv
// ----------------------------------------------------------------------------
// ari_pkg: shared types, tables and GF(2^8) helpers for the round inverter.
// The S-box tables are built at elaboration from the field inverse and the
// affine map, so no runtime logic computes them.
// ----------------------------------------------------------------------------
package ari_pkg;

  // 256 byte entries; entry i sits in bits [8*i +: 8].
  typedef logic [2047:0] byte_table_t;

  // One item as it moves between pipeline stages.
  typedef struct packed {
    logic         enc;
    logic [127:0] data;
  } stage_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  // a^254, which maps zero to zero.
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] e;
    r = 8'h01;
    base = a;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic byte_table_t build_sbox();
    byte_table_t t;
    logic [7:0] x;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      x = gf_inv(8'(i));
      t[8 * i +: 8] = x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ 8'h63;
    end
    build_sbox = t;
  endfunction

  function automatic byte_table_t build_inv_sbox();
    byte_table_t f;
    byte_table_t t;
    logic [7:0]  v;
    f = build_sbox();
    t = '0;
    for (int i = 0; i < 256; i++) begin
      v = f[8 * i +: 8];
      t[{v, 3'b000} +: 8] = 8'(i);
    end
    build_inv_sbox = t;
  endfunction

  localparam byte_table_t SBOX     = build_sbox();
  localparam byte_table_t INV_SBOX = build_inv_sbox();

endpackage

// File: hw/rtl/ari_key_stage.sv
// ----------------------------------------------------------------------------
// ari_key_stage: first pipeline stage.
// XORs the round key into the round output and registers the result.
// ----------------------------------------------------------------------------
module ari_key_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [127:0]     state,
  input  logic [127:0]     key,
  output logic             valid,
  input  logic             down_stall,
  output ari_pkg::stage_t  item
);

  assign in_stall = valid & down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.enc  <= func;
      item.data <= state ^ key;
    end
  end

endmodule

// File: hw/rtl/ari_mix_stage.sv
// ----------------------------------------------------------------------------
// ari_mix_stage: second pipeline stage.
// Applies InvMixColumns for an encryption round and MixColumns otherwise.
// ----------------------------------------------------------------------------
module ari_mix_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ari_pkg::stage_t  in_item,
  output logic             valid,
  input  logic             down_stall,
  output ari_pkg::stage_t  item
);

  logic [127:0] mixed;

  always_comb begin
    logic [7:0] a [4];
    logic [7:0] m0, m1, m2, m3;
    if (in_item.enc) begin
      m0 = 8'd14; m1 = 8'd11; m2 = 8'd13; m3 = 8'd9;
    end else begin
      m0 = 8'd2;  m1 = 8'd3;  m2 = 8'd1;  m3 = 8'd1;
    end
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = in_item.data[8 * (4 * c + r) +: 8];
      end
      for (int r = 0; r < 4; r++) begin
        mixed[8 * (4 * c + r) +: 8] = ari_pkg::gf_mul(a[r], m0)
                                    ^ ari_pkg::gf_mul(a[(r + 1) % 4], m1)
                                    ^ ari_pkg::gf_mul(a[(r + 2) % 4], m2)
                                    ^ ari_pkg::gf_mul(a[(r + 3) % 4], m3);
      end
    end
  end

  assign in_stall = valid & down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.enc  <= in_item.enc;
      item.data <= mixed;
    end
  end

endmodule

// File: hw/rtl/ari_sub_stage.sv
// ----------------------------------------------------------------------------
// ari_sub_stage: last pipeline stage.
// Permutes the rows and substitutes each byte through the matching S-box.
// ----------------------------------------------------------------------------
module ari_sub_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ari_pkg::stage_t  in_item,
  output logic             valid,
  input  logic             down_stall,
  output logic [127:0]     data
);

  logic [127:0] subbed;

  always_comb begin
    logic [7:0] b;
    subbed = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        // The encryption path undoes ShiftRows, so the row rotates right.
        if (in_item.enc) begin
          b = in_item.data[8 * (4 * ((c - r + 4) % 4) + r) +: 8];
          subbed[8 * (4 * c + r) +: 8] = ari_pkg::INV_SBOX[{b, 3'b000} +: 8];
        end else begin
          b = in_item.data[8 * (4 * ((c + r) % 4) + r) +: 8];
          subbed[8 * (4 * c + r) +: 8] = ari_pkg::SBOX[{b, 3'b000} +: 8];
        end
      end
    end
  end

  assign in_stall = valid & down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= subbed;
    end
  end

endmodule

// File: hw/rtl/aes_round_inverter_top.sv
// ----------------------------------------------------------------------------
// aes_round_inverter_top: recovers the state that entered one AES round.
// Key XOR, column mix and row shift with S-box each own one register stage,
// in that order, from an accepted transaction to its result.
// Throughput is one transaction per cycle; a stall holds only the stages
// that are full, so bubbles close up. Reset clears the stage valid bits.
// ----------------------------------------------------------------------------
module aes_round_inverter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] state_low,
  input  logic [63:0] state_high,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] prior_low,
  output logic [63:0] prior_high
);

  logic            key_valid;
  logic            mix_valid;
  logic            mix_stall;
  logic            sub_stall;
  ari_pkg::stage_t key_item;
  ari_pkg::stage_t mix_item;
  logic [127:0]    prior;

  ari_key_stage u_key (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .state      ({state_high, state_low}),
    .key        ({key_high, key_low}),
    .valid      (key_valid),
    .down_stall (mix_stall),
    .item       (key_item)
  );

  ari_mix_stage u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (key_valid),
    .in_stall   (mix_stall),
    .in_item    (key_item),
    .valid      (mix_valid),
    .down_stall (sub_stall),
    .item       (mix_item)
  );

  ari_sub_stage u_sub (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mix_valid),
    .in_stall   (sub_stall),
    .in_item    (mix_item),
    .valid      (out_valid),
    .down_stall (out_stall),
    .data       (prior)
  );

  assign prior_low  = prior[63:0];
  assign prior_high = prior[127:64];

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for aes_round_inverter_top.
// A short table of directed round outputs and keys runs first, then several
// hundred random transactions. Each without a known result is predicted by an
// independent model of the inverse round, and every result is compared in
// order. Both channels idle and stall in random bursts; one long output
// hold fills the pipeline, and one pause lets the block drain completely.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 850;
  localparam int CALM_ITEMS     = 100;
  localparam int HOLD_AT_ITEM   = 200;
  localparam int DRAIN_AT_ITEM  = 450;
  localparam int HOLD_CYCLES    = 80;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [63:0] state_low;
  logic [63:0] state_high;
  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] prior_low;
  logic [63:0] prior_high;

  typedef struct packed {
    logic        enc;
    logic [63:0] st_lo;
    logic [63:0] st_hi;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
  } round_txn_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } prior_t;

  typedef struct packed {
    round_txn_t  txn;
    logic        known;
    logic [63:0] want_lo;
    logic [63:0] want_hi;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 16;

  // Rows with known set carry a result that follows from the S-box of a
  // single repeated byte; the rest are checked against the predictor.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      1'b1, 64'h6363636363636363, 64'h6363636363636363},
    '{'{1'b1, 64'h0, 64'h0, 64'h0, 64'h0},
      1'b1, 64'h5252525252525252, 64'h5252525252525252},
    '{'{1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0, 64'h0},
      1'b1, 64'h1616161616161616, 64'h1616161616161616},
    '{'{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0, 64'h0},
      1'b1, 64'h7d7d7d7d7d7d7d7d, 64'h7d7d7d7d7d7d7d7d},
    '{'{1'b0, 64'h0, 64'h0, 64'hffffffffffffffff, 64'hffffffffffffffff},
      1'b1, 64'h1616161616161616, 64'h1616161616161616},
    '{'{1'b1, 64'h0, 64'h0, 64'hffffffffffffffff, 64'hffffffffffffffff},
      1'b1, 64'h7d7d7d7d7d7d7d7d, 64'h7d7d7d7d7d7d7d7d},
    '{'{1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff,
        64'hffffffffffffffff, 64'hffffffffffffffff},
      1'b1, 64'h6363636363636363, 64'h6363636363636363},
    '{'{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff,
        64'hffffffffffffffff, 64'hffffffffffffffff},
      1'b1, 64'h5252525252525252, 64'h5252525252525252},
    '{'{1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b0, 64'h8000000000000001, 64'h0000000000000080,
        64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
      1'b0, 64'h0, 64'h0},
    '{'{1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
        64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b1, 64'h00000000000000ff, 64'hff00000000000000, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b0, 64'h00000000000000ff, 64'hff00000000000000, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b0, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0},
    '{'{1'b1, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h0, 64'h0},
      1'b0, 64'h0, 64'h0}
  };

  prior_t     pending_priors [$];
  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_rev [256];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  bit         hold_request = 1'b0;

  aes_round_inverter_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .state_low  (state_low),
    .state_high (state_high),
    .key_low    (key_low),
    .key_high   (key_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prior_low  (prior_low),
    .prior_high (prior_high)
  );

  initial clk = 1'b0;

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW clk = 1'b0;
  end

  function automatic logic [7:0] ff_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    logic [7:0] mul;
    acc = 8'h00;
    sh = a;
    mul = b;
    while (mul != 8'h00) begin
      if (mul[0]) acc = acc ^ sh;
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ 8'h1b) : {sh[6:0], 1'b0};
      mul = mul >> 1;
    end
    return acc;
  endfunction

  // Key XOR, then the column mix, row shift and S-box that undo the round.
  function automatic prior_t predict_prior(input round_txn_t t);
    logic [127:0] blk;
    logic [127:0] res;
    logic [7:0]   col [4];
    logic [7:0]   coef [4];
    logic [7:0]   mixed [16];
    logic [7:0]   outb [16];
    blk = {t.st_hi, t.st_lo} ^ {t.key_hi, t.key_lo};
    if (t.enc) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = blk[32*c + 8*r +: 8];
      for (int r = 0; r < 4; r++) begin
        mixed[4*c + r] = ff_mult(col[r], coef[0]) ^ ff_mult(col[(r + 1) % 4], coef[1]) ^
                         ff_mult(col[(r + 2) % 4], coef[2]) ^
                         ff_mult(col[(r + 3) % 4], coef[3]);
      end
    end
    // The S-box works per byte, so it can be applied while the rows move.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (t.enc) outb[4*((c + r) % 4) + r] = sbox_rev[mixed[4*c + r]];
        else outb[4*c + r] = sbox_fwd[mixed[4*((c + r) % 4) + r]];
      end
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = outb[i];
    return '{res[63:0], res[127:64]};
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Bytes drawn from zero, all ones and random values.
  function automatic logic [63:0] byte_mix();
    logic [63:0] w;
    int          pick;
    for (int i = 0; i < 8; i++) begin
      pick = $urandom_range(0, 2);
      w[8*i +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
    end
    return w;
  endfunction

  function automatic round_txn_t rand_txn();
    round_txn_t t;
    int         mode;
    mode = $urandom_range(0, 9);
    t.enc = 1'($urandom_range(0, 1));
    t.st_lo = rand_word();
    t.st_hi = rand_word();
    t.key_lo = rand_word();
    t.key_hi = rand_word();
    case (mode)
      6: begin
        t.key_lo = t.st_lo;
        t.key_hi = t.st_hi;
      end
      7: begin
        t.key_lo = t.st_lo ^ byte_mix();
        t.key_hi = t.st_hi ^ byte_mix();
      end
      8: begin
        t.key_lo = t.st_lo ^ (64'h1 << $urandom_range(0, 63));
        t.key_hi = t.st_hi;
      end
      default: ;
    endcase
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_txn(input round_txn_t t, input prior_t want);
    in_valid <= 1'b1;
    func <= t.enc;
    state_low <= t.st_lo;
    state_high <= t.st_hi;
    key_low <= t.key_lo;
    key_high <= t.key_hi;
    @(posedge clk);
    while (in_stall) begin
      @(negedge clk);
      @(posedge clk);
    end
    pending_priors.push_back(want);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    round_txn_t t;
    prior_t     want;
    logic [7:0] recip;
    logic [7:0] sb;
    bit         sender_idles;
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    state_low = 64'h0;
    state_high = 64'h0;
    key_low = 64'h0;
    key_high = 64'h0;

    // S-box tables from a brute-force field inverse and the affine map.
    for (int v = 0; v < 256; v++) begin
      recip = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (ff_mult(8'(v), 8'(c)) == 8'h01) recip = 8'(c);
      end
      sb = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]} ^
           {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
      sbox_fwd[v] = sb;
      sbox_rev[sb] = 8'(v);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
      t = DIRECTED[i].txn;
      if (DIRECTED[i].known) want = '{DIRECTED[i].want_lo, DIRECTED[i].want_hi};
      else want = predict_prior(t);
      send_txn(t, want);
    end

    sender_idles = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) sender_idles = ($urandom_range(0, 2) != 0);
      if (i == HOLD_AT_ITEM) hold_request = 1'b1;
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i == DRAIN_AT_ITEM) begin
        // Let every outstanding transaction come out before going on.
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_priors.size() != 0);
      end else if (!calm && !hold_request && sender_idles && $urandom_range(0, 4) == 0) begin
        pause_sender($urandom_range(1, 9));
      end
      t = rand_txn();
      send_txn(t, predict_prior(t));
    end
    in_valid <= 1'b0;

    while (pending_priors.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Output side: random stall bursts, quiet stretches and one long hold.
  initial begin
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (calm) begin
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    prior_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_priors.size() == 0) begin
        $error("result with no transaction pending: prior_low %h prior_high %h",
               prior_low, prior_high);
        mismatch_count++;
      end else begin
        want = pending_priors.pop_front();
        if (prior_low !== want.lo) begin
          $error("prior_low: expected %h, actual %h", want.lo, prior_low);
          mismatch_count++;
        end
        if (prior_high !== want.hi) begin
          $error("prior_high: expected %h, actual %h", want.hi, prior_high);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ari_pkg.sv
hw/rtl/ari_key_stage.sv
hw/rtl/ari_mix_stage.sv
hw/rtl/ari_sub_stage.sv
hw/rtl/aes_round_inverter_top.sv
tb/sv/tb_top.sv
